// ----- hw/rtl/grg_pkg.sv -----
// ----------------------------------------------------------------------------
// grg_pkg
// Shared types and constants for the Givens rotation generator pipeline.
// ----------------------------------------------------------------------------
package grg_pkg;

  localparam int unsigned InW   = 32;
  localparam int unsigned SqW   = 64;
  localparam int unsigned RootW = 32;
  localparam int unsigned QuoW  = 31;
  localparam int unsigned RadW  = 33;

  // Fixed-point one in Q2.30.
  localparam logic [InW-1:0] QOne = 32'h4000_0000;

  // Sideband that rides along with each beat through the long stages.
  typedef struct packed {
    logic [InW-1:0] amag;
    logic [InW-1:0] bmag;
    logic           aneg;
    logic           bneg;
  } grg_tag_t;

endpackage

// ----- hw/rtl/givens_rotation_generate.sv -----
// Each accepted beat (a, b) returns one result beat: the rotation cosine a/h
// and sine b/h in signed Q2.30 and the signed radius h, whose magnitude is
// floor(sqrt(a*a + b*b)). A new beat can enter every cycle unless the pipeline
// is frozen. The square root resolves one root bit per stage (32 stages), and
// the divider resolves one quotient bit per stage (31 stages). The whole
// pipeline freezes while a result beat is stalled, so item_stall follows
// result_valid and result_stall.
// ----------------------------------------------------------------------------
// givens_rotation_generate
// Deeply pipelined Givens rotation generator: squares, integer square root,
// two restoring divisions and sign fix-up.
// ----------------------------------------------------------------------------
module givens_rotation_generate (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic signed [grg_pkg::InW-1:0]   first_value,
  input  logic signed [grg_pkg::InW-1:0]   second_value,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic signed [grg_pkg::InW-1:0]   cosine_part,
  output logic signed [grg_pkg::InW-1:0]   sine_part,
  output logic signed [grg_pkg::RadW-1:0]  radius
);
  import grg_pkg::*;

  logic              en;
  logic              v0, v1, v2;
  grg_tag_t          t0, t1, t2;
  logic [SqW-1:0]    asq, bsq, sumsq;
  logic              sq_valid;
  logic [RootW-1:0]  sq_root;
  grg_tag_t          sq_tag;
  logic              dv_valid;
  logic [RootW-1:0]  dv_hyp;
  logic [QuoW-1:0]   cquo, squo;
  grg_tag_t          dv_tag;
  logic              hneg;
  logic [InW-1:0]    cmag, smag;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= item_valid;
      v1 <= v0;
      v2 <= v1;
    end
    if (en) begin
      // Two's complement magnitude; the most negative value maps to 2^31.
      t0.aneg <= first_value[InW-1];
      t0.bneg <= second_value[InW-1];
      t0.amag <= first_value[InW-1] ? InW'(-first_value) : first_value;
      t0.bmag <= second_value[InW-1] ? InW'(-second_value) : second_value;
      asq     <= t0.amag * t0.amag;
      bsq     <= t0.bmag * t0.bmag;
      t1      <= t0;
      sumsq   <= asq + bsq;
      t2      <= t1;
    end
  end

  grg_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .value     (sumsq),
    .in_tag    (t2),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );

  grg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .hyp       (sq_root),
    .in_tag    (sq_tag),
    .out_valid (dv_valid),
    .out_hyp   (dv_hyp),
    .cquo      (cquo),
    .squo      (squo),
    .out_tag   (dv_tag)
  );

  // The larger magnitude sets the sign of h; b wins a tie.
  assign hneg = (dv_tag.amag > dv_tag.bmag) ? dv_tag.aneg : dv_tag.bneg;
  assign cmag = {1'b0, cquo};
  assign smag = {1'b0, squo};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv_valid;
    end
    if (en) begin
      if (dv_hyp == '0) begin
        cosine_part <= QOne;
        sine_part   <= '0;
        radius      <= '0;
      end else begin
        cosine_part <= (dv_tag.aneg != hneg) ? -cmag : cmag;
        sine_part   <= (dv_tag.bneg != hneg) ? -smag : smag;
        radius      <= hneg ? -{1'b0, dv_hyp} : {1'b0, dv_hyp};
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    result_valid && radius == '0 |-> cosine_part == QOne && sine_part == '0)
    else $error("zero radius without unit cosine");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> cosine_part <= $signed(QOne) && cosine_part >= -$signed(QOne))
    else $error("cosine out of range");

  a_sin_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sine_part <= $signed(QOne) && sine_part >= -$signed(QOne))
    else $error("sine out of range");

endmodule

// ----- hw/rtl/grg_sqrt.sv -----
// ----------------------------------------------------------------------------
// grg_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module grg_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [grg_pkg::SqW-1:0]       value,
  input  grg_pkg::grg_tag_t             in_tag,
  output logic                          out_valid,
  output logic [grg_pkg::RootW-1:0]     root,
  output grg_pkg::grg_tag_t             out_tag
);
  import grg_pkg::*;

  localparam int unsigned RemW = RootW + 3;

  logic                 vld  [0:RootW];
  logic [SqW-1:0]       val  [0:RootW];
  logic [RemW-1:0]      rem  [0:RootW];
  logic [RootW-1:0]     rt   [0:RootW];
  grg_tag_t             tag  [0:RootW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      val[0] <= value;
      rem[0] <= '0;
      rt[0]  <= '0;
      tag[0] <= in_tag;
    end
  end

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic [RemW-1:0] shifted;
    logic [RemW-1:0] trial;
    logic            take;

    // Bring down the next two bits of the radicand and try a one bit.
    assign shifted = {rem[s][RemW-3:0], val[s][SqW-1-2*s -: 2]};
    assign trial   = {1'b0, rt[s], 2'b01};
    assign take    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        val[s+1] <= val[s];
        rem[s+1] <= take ? shifted - trial : shifted;
        rt[s+1]  <= {rt[s][RootW-2:0], take};
        tag[s+1] <= tag[s];
      end
    end
  end

  assign out_valid = vld[RootW];
  assign root      = rt[RootW];
  assign out_tag   = tag[RootW];

endmodule

// ----- hw/rtl/grg_div.sv -----
// ----------------------------------------------------------------------------
// grg_div
// Pipelined restoring divider forming both Q2.30 quotients mag * 2^30 / h.
// ----------------------------------------------------------------------------
module grg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [grg_pkg::RootW-1:0]     hyp,
  input  grg_pkg::grg_tag_t             in_tag,
  output logic                          out_valid,
  output logic [grg_pkg::RootW-1:0]     out_hyp,
  output logic [grg_pkg::QuoW-1:0]      cquo,
  output logic [grg_pkg::QuoW-1:0]      squo,
  output grg_pkg::grg_tag_t             out_tag
);
  import grg_pkg::*;

  localparam int unsigned RW = RootW + 1;

  logic              vld [0:QuoW];
  logic [RootW-1:0]  hv  [0:QuoW];
  logic [RW-1:0]     ra  [0:QuoW];
  logic [RW-1:0]     rb  [0:QuoW];
  logic [QuoW-1:0]   qa  [0:QuoW];
  logic [QuoW-1:0]   qb  [0:QuoW];
  grg_tag_t          tag [0:QuoW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      hv[0]  <= hyp;
      ra[0]  <= {1'b0, in_tag.amag};
      rb[0]  <= {1'b0, in_tag.bmag};
      qa[0]  <= '0;
      qb[0]  <= '0;
      tag[0] <= in_tag;
    end
  end

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic [RW-1:0] pa;
    logic [RW-1:0] pb;
    logic [RW-1:0] dv;
    logic          ta;
    logic          tb;

    // The first step works on the magnitude itself; later steps shift in zeros.
    if (s == 0) begin : g_first
      assign pa = ra[s];
      assign pb = rb[s];
    end else begin : g_next
      assign pa = {ra[s][RW-2:0], 1'b0};
      assign pb = {rb[s][RW-2:0], 1'b0};
    end
    assign dv = {1'b0, hv[s]};
    assign ta = pa >= dv;
    assign tb = pb >= dv;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        hv[s+1]  <= hv[s];
        ra[s+1]  <= ta ? pa - dv : pa;
        rb[s+1]  <= tb ? pb - dv : pb;
        qa[s+1]  <= {qa[s][QuoW-2:0], ta};
        qb[s+1]  <= {qb[s][QuoW-2:0], tb};
        tag[s+1] <= tag[s];
      end
    end
  end

  assign out_valid = vld[QuoW];
  assign out_hyp   = hv[QuoW];
  assign cquo      = qa[QuoW];
  assign squo      = qb[QuoW];
  assign out_tag   = tag[QuoW];

endmodule
